// ===== rtl/mqm_pkg.sv =====
// shared types and constants of the monotonic minimum queue
// no dependencies; imported by mqm_cell and min_queue_monotonic_top
package mqm_pkg;

  localparam int DATA_W = 32;

  // opcode of an input word
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes of a result word
  localparam logic [1:0] ST_PUSHED    = 2'd0;
  localparam logic [1:0] ST_POPPED    = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // contents of one minima cell
  typedef struct packed {
    logic              occ;
    logic [DATA_W-1:0] value;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              push;
    logic              shift;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/mqm_cell.sv =====
// one cell of the minima chain: holds one candidate minimum
// depends on mqm_pkg
module mqm_cell
  import mqm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  logic      prev_keep,
  input  entry_t    next_entry,
  output logic      keep,
  output entry_t    entry
);

  logic              occ_r, occ_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  // a cell survives a push unless it holds something greater than the new word
  assign keep = occ_r && !($signed(value_r) > $signed(cmd.value));

  // push takes the first dropped or empty slot and clears the slots after it, shift moves toward the front
  always_comb begin
    occ_nxt   = occ_r;
    value_nxt = value_r;
    if (cmd.shift) begin
      occ_nxt   = next_entry.occ;
      value_nxt = next_entry.value;
    end else if (cmd.push && !keep) begin
      occ_nxt   = prev_keep;
      value_nxt = cmd.value;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // stored value
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign entry.occ   = occ_r;
  assign entry.value = value_r;

endmodule

// ===== rtl/min_queue_monotonic_top.sv =====
// push: result in the next cycle, a push word is accepted every cycle while idle
// pop: the head word is read into a register, then busy is high for one cycle
//   while the chain may shift and the result is registered; busy blocks start
// results are strobed on out_valid for one cycle, the receiver cannot stall
// synchronous active-low reset empties the queue; memory contents stay as they are
// depends on mqm_pkg and mqm_cell
module min_queue_monotonic_top
  import mqm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_min_value,
  output logic [1:0]        out_status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_min_r, out_min_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              accept;
  logic              full;
  logic              empty;
  logic              do_push;
  logic              do_read;
  cell_cmd_t         cmd;
  logic   [QUEUE_DEPTH-1:0] keep_vec;
  logic   [QUEUE_DEPTH-1:0] occ_vec;
  entry_t            cells [QUEUE_DEPTH];

  assign busy    = (state_r == S_POP);
  assign accept  = start && !busy;
  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = accept && (in_opcode == OP_PUSH) && !full;
  assign do_read = accept && (in_opcode == OP_POP) && !empty;

  // command to the minima chain
  assign cmd.push  = do_push;
  assign cmd.shift = busy && (rd_data_r == cells[0].value);
  assign cmd.value = in_value;

  // chain of minima cells, front at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_keep;
    entry_t next_entry;
    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_keep = keep_vec[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = cells[i+1];
    end
    mqm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_keep  (prev_keep),
      .next_entry (next_entry),
      .keep       (keep_vec[i]),
      .entry      (cells[i])
    );
    assign occ_vec[i] = cells[i].occ;
  end

  // fifo memory: write at tail on push, registered read at head on pop
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= in_value;
    end
    if (do_read) begin
      rd_data_r <= mem[head_r];
    end
  end

  // pointers, count, state and result word
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_min_nxt    = '0;
    out_status_nxt = ST_PUSHED;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          if (in_opcode == OP_PUSH) begin
            if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_PUSHED;
              tail_nxt = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
            end
          end else if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_POP;
          end
        end
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_POPPED;
        out_min_nxt    = cells[0].value;
        head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_status_r;

`ifndef ASSERT_OFF
  // minima chain holds something exactly when the fifo does
  a_front_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cells[0].occ == (cnt_r != '0))
    else $error("minima front occupancy disagrees with fifo count");

  // occupied cells form a contiguous run from the front
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("gap in minima chain");

  // a pop in flight always delivers a popped word next cycle
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && (out_status == ST_POPPED))
    else $error("pop did not complete");

  // count never exceeds depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fifo count overflow");
`endif

endmodule
